/* rtl/core/dqd_pkg.sv */
// ----------------------------------------------------------------------------
// dqd_pkg
// Shared types, masks and the x4 transition table for the dual quadrature
// decoder.
// ----------------------------------------------------------------------------
package dqd_pkg;

  localparam int COUNT_W = 32;
  localparam int PINS_W  = 4;
  localparam int PHASE_W = 2;

  // pin groups inside one sample
  localparam logic [PINS_W-1:0] LEFT_MASK  = 4'h3;
  localparam logic [PINS_W-1:0] RIGHT_MASK = 4'hC;
  localparam logic [PINS_W-1:0] PINS_MASK  = 4'hF;

  // read_select codes
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic [PHASE_W-1:0]        phase_t;

  // per-encoder decoder state
  typedef struct packed {
    phase_t phase;
    count_t count;
  } enc_state_t;

  // x4 table: index is previous phase then current phase, result -1, 0 or +1
  function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      default: step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

/* rtl/core/dqd_stream_if.sv */
// ----------------------------------------------------------------------------
// dqd_stream_if
// Valid/ready channels of the dual quadrature decoder: pin samples in,
// selected position count out.
// ----------------------------------------------------------------------------
interface dqd_in_if import dqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PINS_W-1:0] pins;
  logic              clear_counts;
  logic              read_select;

  modport source (output valid, output pins, output clear_counts,
                  output read_select, input ready);
  modport sink   (input valid, input pins, input clear_counts,
                  input read_select, output ready);
endinterface

interface dqd_out_if import dqd_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t selected_count;

  modport source (output valid, output selected_count, input ready);
  modport sink   (input valid, input selected_count, output ready);
endinterface

/* rtl/core/dqd_enc_update.sv */
// ----------------------------------------------------------------------------
// dqd_enc_update
// Next state of one encoder: decodes a change of its A/B pair through the x4
// table, steps the count and applies the clear.
// ----------------------------------------------------------------------------
module dqd_enc_update import dqd_pkg::*; (
  input  enc_state_t cur_state,
  input  phase_t     pair,
  input  phase_t     last_pair,
  input  logic       primed,
  input  logic       clear,
  output enc_state_t next_state
);

  logic              changed;
  logic signed [1:0] step;

  // decode only on a change of this pair once primed
  assign changed = primed && (pair != last_pair);
  assign step    = step_lookup({cur_state.phase, pair});

  always_comb begin
    next_state = cur_state;
    if (changed) begin
      next_state.phase = pair;
      next_state.count = cur_state.count + count_t'(step);
    end
    // clear wins over a step in the same item
    if (clear) begin
      next_state.count = '0;
    end
  end

endmodule

/* rtl/core/dual_quadrature_decoder.sv */
// ----------------------------------------------------------------------------
// dual_quadrature_decoder
// Two x4 quadrature decoders fed from one 4-pin sample stream.
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one item per pin sample; pins[1:0] left A/B, pins[3:2] right A/B,
//            clear_counts zeroes both counts, read_select picks the count
//            reported (0 left, 1 right)
//   out_ch : one item per input item, the selected signed 32-bit count after
//            that sample
//   path   : input register, then decode and count update into the result
//            register; a held output keeps the item in the input register
//   throughput: one item per cycle unless out_ch stalls; the count update is a
//            table lookup and one 32-bit add per encoder between the input and result registers
//   reset  : counts, phases and last sample go to zero; the first item after
//            reset only latches the pins and reports the selected count
//   stall  : a held output keeps its item; the input register still takes one
//            more item, then in_ch.ready drops until out_ch.ready returns
// ----------------------------------------------------------------------------
module dual_quadrature_decoder import dqd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  dqd_in_if.sink    in_ch,
  dqd_out_if.source out_ch
);

  // input register
  logic              in_vld_r;
  logic [PINS_W-1:0] pins_r;
  logic              clr_r;
  logic              sel_r;

  // decoder state
  logic [PINS_W-1:0] last_sample_r;
  logic              primed_r;
  enc_state_t        left_r, left_nxt;
  enc_state_t        right_r, right_nxt;

  // result register
  logic              out_vld_r;
  count_t            out_count_r;
  count_t            out_count_nxt;

  logic              advance;
  logic              in_fire;

  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // per-encoder update
  dqd_enc_update u_left (
    .cur_state  (left_r),
    .pair       (pins_r[1:0] & LEFT_MASK[1:0]),
    .last_pair  (last_sample_r[1:0]),
    .primed     (primed_r),
    .clear      (clr_r),
    .next_state (left_nxt)
  );

  dqd_enc_update u_right (
    .cur_state  (right_r),
    .pair       (pins_r[3:2] & RIGHT_MASK[3:2]),
    .last_pair  (last_sample_r[3:2]),
    .primed     (primed_r),
    .clear      (clr_r),
    .next_state (right_nxt)
  );

  assign out_count_nxt = (sel_r == SEL_RIGHT) ? right_nxt.count : left_nxt.count;

  // control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      primed_r      <= 1'b0;
      last_sample_r <= '0;
      left_r        <= '0;
      right_r       <= '0;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r     <= 1'b1;
        primed_r      <= 1'b1;
        last_sample_r <= pins_r & PINS_MASK;
        left_r        <= left_nxt;
        right_r       <= right_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pins_r <= in_ch.pins;
      clr_r  <= in_ch.clear_counts;
      sel_r  <= in_ch.read_select;
    end
    if (advance) begin
      out_count_r <= out_count_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.selected_count = out_count_r;

  // a clear item reports zero
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && clr_r |=> out_vld_r && (out_count_r == '0))
    else $error("clear item did not report zero");

  // a held input item is not dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("pending input item lost");

  // without clear the left count moves by at most one per item
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && !clr_r |=> (left_r.count == $past(left_r.count)) ||
      (left_r.count == $past(left_r.count) + count_t'(1)) ||
      (left_r.count == $past(left_r.count) - count_t'(1)))
    else $error("left count jumped by more than one");

  // the priming item changes no count
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && !primed_r && !clr_r |=>
      $stable(left_r.count) && $stable(right_r.count))
    else $error("count changed on priming item");

endmodule
